FILE: src/dppp_pkg.sv
// Shared types and constants for the dual patience pile placement block.
package dppp_pkg;

    // Widths of result fields that are fixed at the ports.
    localparam int PILE_IDX_W = 6;
    localparam int OUT_POS_W  = 16;

    typedef enum logic {
        GAME_ASC  = 1'b0,
        GAME_DESC = 1'b1
    } t_game;

    localparam logic STATUS_PLACED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // Control part of an item as it travels along the row of pile cells.
    typedef struct packed {
        logic                  valid;
        logic                  start_new;
        t_game                 game;
        logic                  found;
        logic [PILE_IDX_W-1:0] pile;
    } t_ctl;

endpackage

FILE: src/dppp_cell.sv
// One pile cell: holds the tail and length of one pile for each game.
module dppp_cell #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16,
    parameter int PILE_ID        = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  dppp_pkg::t_ctl                   i_ctl,
    input  logic signed [VALUE_WIDTH-1:0]    i_key,
    input  logic        [POSITION_WIDTH-1:0] i_pos,
    output dppp_pkg::t_ctl                   o_ctl,
    output logic signed [VALUE_WIDTH-1:0]    o_key,
    output logic        [POSITION_WIDTH-1:0] o_pos
);

    // Index 0 belongs to the ascending game, index 1 to the descending game.
    logic                             r_act [2];
    logic signed [VALUE_WIDTH-1:0]    r_tail [2];
    logic        [POSITION_WIDTH-1:0] r_len [2];

    dppp_pkg::t_ctl                   r_ctl;
    logic signed [VALUE_WIDTH-1:0]    r_key;
    logic        [POSITION_WIDTH-1:0] r_pos;

    logic                             w_g;
    logic                             w_act_g;
    logic                             w_fits;
    logic                             w_hit;
    logic signed [VALUE_WIDTH-1:0]    w_tail_g;
    logic        [POSITION_WIDTH-1:0] w_len_g;

    always_comb begin
        w_g      = (i_ctl.game == dppp_pkg::GAME_DESC);
        w_act_g  = r_act[w_g] && !i_ctl.start_new;
        w_tail_g = r_tail[w_g];
        w_len_g  = r_len[w_g];
        if (i_ctl.game == dppp_pkg::GAME_ASC) begin
            w_fits = (w_tail_g <= i_key);
        end else begin
            w_fits = (w_tail_g >= i_key);
        end
        // An inactive cell is the first free pile, since piles open in order.
        w_hit = i_ctl.valid && !i_ctl.found && (!w_act_g || w_fits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act[0]    <= 1'b0;
            r_act[1]    <= 1'b0;
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid     <= i_ctl.valid;
            r_ctl.start_new <= i_ctl.start_new;
            r_ctl.game      <= i_ctl.game;
            r_key           <= i_key;
            // A new data set empties both games here before the sample is placed.
            if (i_ctl.valid && i_ctl.start_new) begin
                r_act[0] <= w_hit && !w_g;
                r_act[1] <= w_hit && w_g;
            end else if (w_hit) begin
                r_act[w_g] <= 1'b1;
            end
            if (w_hit) begin
                r_tail[w_g]  <= i_key;
                r_ctl.found  <= 1'b1;
                r_ctl.pile   <= dppp_pkg::PILE_IDX_W'(PILE_ID);
                if (w_act_g) begin
                    r_pos <= w_len_g;
                    if (w_len_g != '1) begin
                        r_len[w_g] <= w_len_g + POSITION_WIDTH'(1);
                    end
                end else begin
                    r_pos      <= '0;
                    r_len[w_g] <= POSITION_WIDTH'(1);
                end
            end else begin
                r_ctl.found <= i_ctl.found;
                r_ctl.pile  <= i_ctl.pile;
                r_pos       <= i_pos;
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_key = r_key;
    assign o_pos = r_pos;

endmodule

FILE: src/dual_patience_pile_placement.sv
// Top level of the dual patience pile placement block.
//
//  channel  direction  valid     ready     payload
//  sample   in         i_valid   o_ready   i_sample_value, i_start_new
//  result   out        o_valid   i_ready   o_game, o_pile_index, o_position_in_pile, o_status
//
// A sample passes an entry register, then the register of each pile cell in
// turn, then the output register.
// The row of cells is a pipeline, so one sample can be taken in every cycle while it does not stall.
// Reset at once clears the pile valid flags and the previous sample, and sets the mode to ascending.
// The row only stalls when its last cell and the output register both hold a
// result that the downstream side has not yet taken.
module dual_patience_pile_placement #(
    parameter int MAX_PILES      = 64,
    parameter int POSITION_WIDTH = 16,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample_value,
    input  logic        i_start_new,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_game,
    output logic [5:0]  o_pile_index,
    output logic [15:0] o_position_in_pile,
    output logic        o_status
);

    logic signed [VALUE_WIDTH-1:0]    w_key_in;
    logic signed [VALUE_WIDTH-1:0]    w_prev;
    logic                             w_rise;
    logic                             w_adv;
    logic                             w_take;

    logic signed [VALUE_WIDTH-1:0]    r_prev;
    logic                             r_mode;

    dppp_pkg::t_ctl                   r_ent_ctl;
    logic signed [VALUE_WIDTH-1:0]    r_ent_key;

    dppp_pkg::t_ctl                   w_ctl [MAX_PILES+1];
    logic signed [VALUE_WIDTH-1:0]    w_key [MAX_PILES+1];
    logic        [POSITION_WIDTH-1:0] w_pos [MAX_PILES+1];

    logic                             r_o_valid;
    dppp_pkg::t_ctl                   r_o_ctl;
    logic        [POSITION_WIDTH-1:0] r_o_pos;

    generate
        if (VALUE_WIDTH <= 32) begin : g_key_narrow
            assign w_key_in = i_sample_value[VALUE_WIDTH-1:0];
        end else begin : g_key_wide
            assign w_key_in = VALUE_WIDTH'(signed'(i_sample_value));
        end
    endgenerate

    // A new data set judges the sample against zero, and a tie goes to the ascending mode.
    always_comb begin
        w_prev = i_start_new ? '0 : r_prev;
        if (w_key_in > w_prev) begin
            w_rise = 1'b1;
        end else if (w_key_in < w_prev) begin
            w_rise = 1'b0;
        end else begin
            w_rise = i_start_new ? 1'b1 : r_mode;
        end
    end

    assign w_adv   = !r_o_valid || i_ready || !w_ctl[MAX_PILES].valid;
    assign o_ready = w_adv;
    assign w_take  = i_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev          <= '0;
            r_mode          <= 1'b1;
            r_ent_ctl.valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_prev <= w_key_in;
                r_mode <= w_rise;
            end
            if (w_adv) begin
                r_ent_ctl.valid     <= i_valid;
                r_ent_ctl.start_new <= i_start_new;
                r_ent_ctl.game      <= w_rise ? dppp_pkg::GAME_ASC : dppp_pkg::GAME_DESC;
                r_ent_ctl.found     <= 1'b0;
                r_ent_ctl.pile      <= '0;
                r_ent_key           <= w_key_in;
            end
        end
    end

    assign w_ctl[0] = r_ent_ctl;
    assign w_key[0] = r_ent_key;
    assign w_pos[0] = '0;

    generate
        for (genvar k = 0; k < MAX_PILES; k++) begin : g_cell
            dppp_cell #(
                .VALUE_WIDTH    (VALUE_WIDTH),
                .POSITION_WIDTH (POSITION_WIDTH),
                .PILE_ID        (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_ctl   (w_ctl[k]),
                .i_key   (w_key[k]),
                .i_pos   (w_pos[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_key   (w_key[k+1]),
                .o_pos   (w_pos[k+1])
            );
        end
    endgenerate

    // Output register; a sample that no pile took leaves with index and position zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv && w_ctl[MAX_PILES].valid) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctl[MAX_PILES].valid) begin
            r_o_ctl <= w_ctl[MAX_PILES];
            r_o_pos <= w_pos[MAX_PILES];
        end
    end

    assign o_valid            = r_o_valid;
    assign o_game             = r_o_ctl.game;
    assign o_pile_index       = r_o_ctl.pile;
    assign o_position_in_pile = dppp_pkg::OUT_POS_W'(r_o_pos);
    assign o_status           = r_o_ctl.found ? dppp_pkg::STATUS_PLACED
                                              : dppp_pkg::STATUS_DROPPED;

    a_drop_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dppp_pkg::STATUS_DROPPED)
            |-> (o_pile_index == '0 && o_position_in_pile == '0))
        else $error("dropped sample reports a pile or position");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_o_valid && !i_ready && w_ctl[MAX_PILES].valid))
        else $error("row stalled without a waiting result");

    a_entry_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_ent_ctl.valid)
        else $error("transferred sample missing from entry register");

    a_last_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[MAX_PILES].valid && w_ctl[MAX_PILES].found)
            |-> (int'(w_ctl[MAX_PILES].pile) < MAX_PILES))
        else $error("placed sample carries a pile index beyond the table");

endmodule
